[rtl/obst_pkg.sv]
package obst_pkg;

  localparam int FREQ_W = 16;
  localparam int COST_W = 32;
  localparam logic [COST_W-1:0] COST_MAX = '1;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic              last_item;
  } key_item_t;

  typedef struct packed {
    logic [COST_W-1:0] min_cost;
    logic              overflowed;
  } cost_item_t;

  // side flags that travel with the registered memory reads
  typedef struct packed {
    logic left_empty;
    logic right_empty;
    logic low_zero;
  } eval_flags_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_DIAG,
    S_IV,
    S_IV2,
    S_K,
    S_K2,
    S_K3,
    S_WR,
    S_FIN,
    S_FIN2
  } obst_state_t;

endpackage

[rtl/obst_ram.sv]
module obst_ram #(
  parameter int W  = 32,
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [W-1:0]  rdata_a,
  output logic [W-1:0]  rdata_b
);

  logic [W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[rtl/obst_eval.sv]
module obst_eval #(
  parameter int PW = 25,
  parameter int SW = 34
) (
  input  logic                          clk,
  input  logic [PW-1:0]                 wsum,
  input  logic [PW-1:0]                 p_hi,
  input  logic [PW-1:0]                 p_lo,
  input  logic [obst_pkg::COST_W-1:0]   cost_l,
  input  logic [obst_pkg::COST_W-1:0]   cost_r,
  input  obst_pkg::eval_flags_t         flags,
  output logic [SW-1:0]                 c
);
  import obst_pkg::*;

  logic [PW-1:0] fk;
  logic [SW-1:0] c_next;

  // split weight minus the root's own frequency plus both subtree costs
  always_comb begin
    fk = p_hi - (flags.low_zero ? '0 : p_lo);
    c_next = SW'(wsum - fk)
           + (flags.left_empty ? '0 : SW'(cost_l))
           + (flags.right_empty ? '0 : SW'(cost_r));
  end

  always_ff @(posedge clk) begin
    c <= c_next;
  end

endmodule

[rtl/optimal_bst_cost_knuth_core.sv]
// optimal binary search tree cost: key frequencies come in one item per cycle, in key
// order; the item marked last closes the set and starts the interval program, which
// runs on one shared evaluate-and-compare unit fed from block memories for prefix sums,
// interval costs and best roots. the solve walks the diagonal first, then for each
// interval runs a setup and steps through the candidate roots (memory read, cost sum,
// compare), with Knuth's bound keeping the candidates of one diagonal under 2n, and
// writes the best cost and root. no key is taken during the solve, but keys of the next
// set load while a result still waits on the output register. keys beyond MAX_KEYS are
// dropped and reported with the result.
module optimal_bst_cost_knuth_core #(
  parameter int MAX_KEYS = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   key_valid,
  output logic                   key_ready,
  input  obst_pkg::key_item_t    key,
  output logic                   cost_valid,
  input  logic                   cost_ready,
  output obst_pkg::cost_item_t   cost
);
  import obst_pkg::*;

  localparam int IW = $clog2(MAX_KEYS + 2);
  localparam int AW = 2 * IW;
  localparam int PW = FREQ_W + IW;
  localparam int SW = COST_W + 2;
  localparam logic [IW-1:0] ONE = IW'(1);
  localparam logic [IW-1:0] MAXK = IW'(MAX_KEYS);

  obst_state_t state, state_next;

  // set loading
  logic [IW-1:0] kc, kc_new, n;
  logic [PW-1:0] psum;
  logic          ovf;

  // interval walk
  logic [IW-1:0] l, len, r_c, k, hi, arg;
  logic [PW-1:0] wsum;
  logic [SW-1:0] best, c;
  logic          have;
  logic [COST_W-1:0] best_sat;
  eval_flags_t   flags;

  // memory ports
  logic          p_we, c_we, t_we;
  logic [IW-1:0] p_waddr, p_ra, p_rb;
  logic [PW-1:0] p_wdata, p_rd_a, p_rd_b;
  logic [AW-1:0] c_waddr, c_ra, c_rb, t_waddr, t_ra, t_rb;
  logic [COST_W-1:0] c_wdata, c_rd_a, c_rd_b;
  logic [IW-1:0] t_wdata, t_rd_a, t_rd_b;

  assign r_c = l + len;
  assign kc_new = (kc < MAXK) ? kc + ONE : kc;
  assign best_sat = (best > SW'(COST_MAX)) ? COST_MAX : best[COST_W-1:0];

  // prefix sums, entry i holds freq[1] + ... + freq[i]
  obst_ram #(.W(PW), .AW(IW)) u_prefix (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr_a(p_ra), .raddr_b(p_rb), .rdata_a(p_rd_a), .rdata_b(p_rd_b)
  );

  // interval cost table addressed {l, r}
  obst_ram #(.W(COST_W), .AW(AW)) u_cost (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr_a(c_ra), .raddr_b(c_rb), .rdata_a(c_rd_a), .rdata_b(c_rd_b)
  );

  // best root table addressed {l, r}
  obst_ram #(.W(IW), .AW(AW)) u_root (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr_a(t_ra), .raddr_b(t_rb), .rdata_a(t_rd_a), .rdata_b(t_rd_b)
  );

  // shared candidate cost unit
  obst_eval #(.PW(PW), .SW(SW)) u_eval (
    .clk(clk), .wsum(wsum), .p_hi(p_rd_a), .p_lo(p_rd_b),
    .cost_l(c_rd_a), .cost_r(c_rd_b), .flags(flags), .c(c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    key_ready  = 1'b0;
    p_we       = 1'b0;
    p_waddr    = kc + ONE;
    p_wdata    = psum + PW'(key.freq);
    c_we       = 1'b0;
    c_waddr    = {l, l};
    c_wdata    = '0;
    t_we       = 1'b0;
    t_waddr    = {l, l};
    t_wdata    = l;
    p_ra       = r_c;
    p_rb       = l - ONE;
    c_ra       = {l, k - ONE};
    c_rb       = {k + ONE, r_c};
    t_ra       = {l, r_c - ONE};
    t_rb       = {l + ONE, r_c};
    case (state)
      S_LOAD: begin
        key_ready = 1'b1;
        if (key_valid) begin
          p_we = (kc < MAXK);
          if (key.last_item) begin
            state_next = (kc_new == '0) ? S_FIN : S_DIAG;
          end
        end
      end
      S_DIAG: begin
        // single-key intervals: cost zero, root is the key
        c_we = 1'b1;
        t_we = 1'b1;
        if (l == n) begin
          state_next = (n == ONE) ? S_FIN : S_IV;
        end
      end
      S_IV:  state_next = S_IV2;
      S_IV2: state_next = S_K;
      S_K: begin
        p_ra       = k;
        p_rb       = k - ONE;
        state_next = S_K2;
      end
      S_K2: state_next = S_K3;
      S_K3: begin
        state_next = (k == hi) ? S_WR : S_K;
      end
      S_WR: begin
        c_we    = 1'b1;
        c_waddr = {l, r_c};
        c_wdata = best_sat;
        t_we    = 1'b1;
        t_waddr = {l, r_c};
        t_wdata = arg;
        state_next = (r_c == n && len == n - ONE) ? S_FIN : S_IV;
      end
      S_FIN: begin
        c_ra       = {ONE, n};
        state_next = S_FIN2;
      end
      S_FIN2: begin
        c_ra = {ONE, n};
        if (!cost_valid || cost_ready) begin
          state_next = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  // flags are registered like the memory reads, so they line up with the registered read data
  always_ff @(posedge clk) begin
    flags.left_empty  <= (k == l);
    flags.right_empty <= (k == r_c);
    flags.low_zero    <= (p_rb == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kc         <= '0;
      psum       <= '0;
      ovf        <= 1'b0;
      cost_valid <= 1'b0;
    end else begin
      // a new result in the final state takes over the output register
      if (cost_valid && cost_ready && state != S_FIN2) begin
        cost_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (key_valid) begin
            if (kc < MAXK) begin
              kc   <= kc + ONE;
              psum <= p_wdata;
            end else begin
              ovf <= 1'b1;
            end
            if (key.last_item) begin
              n   <= kc_new;
              l   <= ONE;
              len <= '0;
            end
          end
        end
        S_DIAG: begin
          if (l == n) begin
            l   <= ONE;
            len <= ONE;
          end else begin
            l <= l + ONE;
          end
        end
        S_IV2: begin
          // interval weight, then the Knuth bound on the root search
          wsum <= p_rd_a - (flags.low_zero ? '0 : p_rd_b);
          k    <= t_rd_a;
          hi   <= t_rd_b;
          have <= 1'b0;
        end
        S_K3: begin
          // strict less keeps the smallest root on ties
          if (!have || c < best) begin
            best <= c;
            arg  <= k;
            have <= 1'b1;
          end
          if (k != hi) begin
            k <= k + ONE;
          end
        end
        S_WR: begin
          if (r_c == n) begin
            l   <= ONE;
            len <= len + ONE;
          end else begin
            l <= l + ONE;
          end
        end
        S_FIN2: begin
          if (!cost_valid || cost_ready) begin
            cost_valid      <= 1'b1;
            cost.min_cost   <= (n == '0) ? '0 : c_rd_a;
            cost.overflowed <= ovf;
            kc              <= '0;
            psum            <= '0;
            ovf             <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // the solve holds off further keys
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    (key_valid && key_ready && key.last_item) |=> !key_ready)
    else $error("key taken right after last item");

  // candidate never passes the upper bound
  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_K3) |-> (k <= hi))
    else $error("root candidate beyond bound");

  // chosen root lies inside its interval
  a_root_inside: assert property (@(posedge clk) disable iff (rst)
    (state == S_WR) |-> (arg >= l && arg <= r_c))
    else $error("best root outside interval");

  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    kc <= MAXK)
    else $error("key count beyond limit");

endmodule

[bench/testbench.sv]
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import obst_pkg::*;

  localparam int MAX_KEYS   = 256;
  localparam int WDOG_LIMIT = 3_000_000;

  typedef struct {
    logic [FREQ_W-1:0] freq;
    logic              last_item;
    bit                fixed;      // expected result typed in below
    logic [COST_W-1:0] cost;
    logic              ovf;
  } stim_row_t;

  typedef struct {
    bit                fixed;
    logic [COST_W-1:0] cost;
    logic              ovf;
  } fixed_exp_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       key_valid = 1'b0;
  logic       key_ready;
  key_item_t  key = '0;
  logic       cost_valid;
  logic       cost_ready = 1'b0;
  cost_item_t cost;

  optimal_bst_cost_knuth_core #(.MAX_KEYS(MAX_KEYS)) uut (
    .clk(clk), .rst(rst),
    .key_valid(key_valid), .key_ready(key_ready), .key(key),
    .cost_valid(cost_valid), .cost_ready(cost_ready), .cost(cost)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state: accepted keys of the open set and their prefix sums
  int unsigned       set_keys;
  logic              set_ovf;
  logic [31:0]       psum [0:MAX_KEYS];
  logic [31:0]       tree_cost [1:MAX_KEYS+1][0:MAX_KEYS];
  int                root_of [1:MAX_KEYS+1][0:MAX_KEYS];

  cost_item_t  cost_q [$];
  fixed_exp_t  fixed_q [$];
  int          errors, results_seen, keys_sent, sets_sent;
  bit          quiet;      // no idling on either side
  bit          hold_req;   // ask the receiver for a long hold-off
  int          idle_cycles;

  function automatic longint unsigned span_weight(int a, int b);
    if (b < a) return 0;
    return longint'(psum[b]) - longint'(psum[a-1]);
  endfunction

  function automatic longint unsigned span_cost(int a, int b);
    if (b < a) return 0;
    return tree_cost[a][b];
  endfunction

  // interval program with knuth's root bound, smallest root wins ties
  function automatic logic [COST_W-1:0] optimal_cost(int n);
    longint unsigned best, c;
    int lo, hi, arg, r;
    bit have;
    if (n == 0) return '0;
    for (int len = 0; len < n; len++) begin
      for (int l = 1; l + len <= n; l++) begin
        r = l + len;
        if (len == 0) begin
          tree_cost[l][r] = '0;
          root_of[l][r] = l;
        end else begin
          lo = root_of[l][r-1];
          hi = root_of[l+1][r];
          have = 0;
          best = 0;
          arg = l;
          for (int k = lo; k <= hi; k++) begin
            c = span_weight(l, k-1) + span_weight(k+1, r)
              + span_cost(l, k-1) + span_cost(k+1, r);
            if (!have || c < best) begin
              best = c;
              arg = k;
              have = 1;
            end
          end
          if (best > 64'(COST_MAX)) best = 64'(COST_MAX);
          tree_cost[l][r] = best[31:0];
          root_of[l][r] = arg;
        end
      end
    end
    return tree_cost[1][n];
  endfunction

  // key side: fold each accepted item into the model, close the set on last
  always @(posedge clk) begin
    cost_item_t e;
    fixed_exp_t f;
    if (!rst && key_valid && key_ready) begin
      keys_sent++;
      if (set_keys < MAX_KEYS) begin
        set_keys++;
        psum[set_keys] = psum[set_keys-1] + key.freq;
      end else begin
        set_ovf = 1'b1;
      end
      if (key.last_item) begin
        e.min_cost   = optimal_cost(set_keys);
        e.overflowed = set_ovf;
        if (fixed_q.size() > 0) begin
          f = fixed_q.pop_front();
          if (f.fixed) begin
            if (f.cost !== e.min_cost || f.ovf !== e.overflowed) begin
              $error("typed-in expectation differs from prediction: %0d/%0b vs %0d/%0b",
                     f.cost, f.ovf, e.min_cost, e.overflowed);
              errors++;
            end
            e.min_cost   = f.cost;
            e.overflowed = f.ovf;
          end
        end
        cost_q.push_back(e);
        sets_sent++;
        set_keys = 0;
        set_ovf  = 1'b0;
      end
    end
  end

  // result side: compare against the oldest pending cost
  always @(posedge clk) begin
    cost_item_t e;
    if (!rst && cost_valid && cost_ready) begin
      results_seen++;
      if (cost_q.size() == 0) begin
        $error("result with nothing pending: min_cost %0d", cost.min_cost);
        errors++;
      end else begin
        e = cost_q.pop_front();
        if (cost.min_cost !== e.min_cost) begin
          $error("min_cost: expected %0d, got %0d", e.min_cost, cost.min_cost);
          errors++;
        end
        if (cost.overflowed !== e.overflowed) begin
          $error("overflowed: expected %0b, got %0b", e.overflowed, cost.overflowed);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (key_valid && key_ready) || (cost_valid && cost_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WDOG_LIMIT);
        $display("[optimal_bst_cost_knuth_core] ERROR");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random ready, with a long hold-off on request
  initial begin
    int r;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        cost_ready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_req = 0;
      end else if (quiet) begin
        cost_ready <= 1'b1;
        @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          cost_ready <= 1'b1;
          repeat ($urandom_range(1, 4)) @(posedge clk);
        end else if (r < 95) begin
          cost_ready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else begin
          cost_ready <= 1'b0;
          repeat ($urandom_range(20, 80)) @(posedge clk);
        end
      end
    end
  end

  // offer one item; valid stays up across back-to-back items
  task automatic send_key(input logic [FREQ_W-1:0] f, input logic lst);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      key_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    key_valid      <= 1'b1;
    key.freq       <= f;
    key.last_item  <= lst;
    do @(posedge clk); while (!key_ready);
  endtask

  // stop offering and wait until every pending result is back
  task automatic drain();
    key_valid <= 1'b0;
    do @(posedge clk); while (cost_q.size() != 0);
  endtask

  function automatic logic [FREQ_W-1:0] pick_freq();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return FREQ_W'($urandom_range(0, 15));
      default: return FREQ_W'($urandom);
    endcase
  endfunction

  task automatic send_set(input int n);
    for (int i = 0; i < n; i++) send_key(pick_freq(), i == n-1);
  endtask

  stim_row_t directed [] = '{
    // single key, both frequency extremes: depth 0, cost 0
    '{16'h0000, 1'b1, 1, 32'd0,     1'b0},
    '{16'hffff, 1'b1, 1, 32'd0,     1'b0},
    // two equal maximal keys: one of them sits at depth 1
    '{16'hffff, 1'b0, 0, 32'd0,     1'b0},
    '{16'hffff, 1'b1, 1, 32'd65535, 1'b0},
    // all-zero frequencies cost nothing
    '{16'h0000, 1'b0, 0, 32'd0,     1'b0},
    '{16'h0000, 1'b0, 0, 32'd0,     1'b0},
    '{16'h0000, 1'b1, 1, 32'd0,     1'b0},
    // ascending, descending and peaked sets, predicted
    '{16'd1,    1'b0, 0, 32'd0,     1'b0},
    '{16'd2,    1'b0, 0, 32'd0,     1'b0},
    '{16'd3,    1'b1, 0, 32'd0,     1'b0},
    '{16'd40,   1'b0, 0, 32'd0,     1'b0},
    '{16'd30,   1'b0, 0, 32'd0,     1'b0},
    '{16'd20,   1'b0, 0, 32'd0,     1'b0},
    '{16'd10,   1'b1, 0, 32'd0,     1'b0},
    '{16'd5,    1'b0, 0, 32'd0,     1'b0},
    '{16'hffff, 1'b0, 0, 32'd0,     1'b0},
    '{16'd5,    1'b1, 0, 32'd0,     1'b0},
    // equal weights exercise ties between roots
    '{16'd7,    1'b0, 0, 32'd0,     1'b0},
    '{16'd7,    1'b0, 0, 32'd0,     1'b0},
    '{16'd7,    1'b0, 0, 32'd0,     1'b0},
    '{16'd7,    1'b1, 0, 32'd0,     1'b0},
    '{16'hffff, 1'b0, 0, 32'd0,     1'b0},
    '{16'hffff, 1'b0, 0, 32'd0,     1'b0},
    '{16'hffff, 1'b1, 0, 32'd0,     1'b0}
  };

  initial begin
    fixed_exp_t f;
    psum[0] = '0;
    set_keys = 0;
    set_ovf = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows, back to back
    quiet = 1;
    foreach (directed[i]) begin
      if (directed[i].last_item) begin
        f.fixed = directed[i].fixed;
        f.cost  = directed[i].cost;
        f.ovf   = directed[i].ovf;
        fixed_q.push_back(f);
      end
      send_key(directed[i].freq, directed[i].last_item);
    end
    quiet = 0;

    // too many keys: 256 taken, the rest dropped, last mark on a dropped key
    for (int i = 0; i < MAX_KEYS + 2; i++)
      send_key(FREQ_W'($urandom_range(0, 255)), i == MAX_KEYS + 1);

    // let the long solve finish so the hold-off meets an idle block
    drain();

    // hold the receiver off while small sets keep coming
    hold_req = 1;
    repeat (6) send_set($urandom_range(1, 4));
    // pause until everything is back
    drain();

    // random sets, mostly small
    while (keys_sent < 2000) begin
      quiet = ($urandom_range(0, 19) == 0);
      if ($urandom_range(0, 49) == 0) send_set($urandom_range(30, 60));
      else send_set($urandom_range(1, 10));
    end
    quiet = 0;

    drain();
    repeat (200) @(posedge clk);
    $display("covered %0d keys in %0d sets, %0d results checked, incl. overflow set",
             keys_sent, sets_sent, results_seen);
    if (errors == 0 && cost_q.size() == 0)
      $display("[optimal_bst_cost_knuth_core] OK");
    else
      $display("[optimal_bst_cost_knuth_core] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
